// File: hw/rtl/cmfta_pkg.sv
// ----------------------------------------------------------------------------
// cmfta_pkg
// Shared types, constants and the divider step for the cube map texel address
// pipeline.
// ----------------------------------------------------------------------------
package cmfta_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int QW           = FRAC_BITS + 1;   // quotient 0..2^F
  localparam int NW           = 17;              // numerator / divisor width
  localparam int DIV_STAGES   = QW;              // one quotient bit per stage
  localparam int SIZE_W       = 13;
  localparam int TEXEL_W      = 12;
  localparam int PROD_W       = QW + TEXEL_W;
  localparam logic [SIZE_W-1:0] MAX_FACE_SIZE  = 13'd4096;
  localparam logic [SIZE_W-1:0] FACE_SIZE_RST  = 13'd256;
  localparam logic [QW-1:0]     COORD_ONE      = 17'h10000;

  // face codes
  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_BACK   = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  // one divider pipeline slot
  typedef struct packed {
    logic [2:0]    face;
    logic          zero;
    logic [NW-1:0] d;     // 2 * major magnitude
    logic [NW-1:0] ru;    // partial remainders
    logic [NW-1:0] rv;
    logic [QW-1:0] qu;    // quotient bits so far
    logic [QW-1:0] qv;
  } div_slot_t;

  typedef struct packed {
    logic              bit_q;
    logic [NW-1:0]     rem;
  } step_t;

  // restoring division step; the first step has no shift
  function automatic step_t div_step(logic [NW-1:0] r, logic [NW-1:0] d, logic first);
    logic [NW:0] rs;
    logic [NW:0] diff;
    step_t       res;
    rs   = first ? {1'b0, r} : {r, 1'b0};
    diff = rs - {1'b0, d};
    if (rs >= {1'b0, d}) begin
      res.bit_q = 1'b1;
      res.rem   = diff[NW-1:0];
    end else begin
      res.bit_q = 1'b0;
      res.rem   = rs[NW-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/cube_map_face_texel_address_top.sv
// ----------------------------------------------------------------------------
// cube_map_face_texel_address_top
// Cube face selection and texel column/row from a Q1.15 direction vector.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | dir_x, dir_y, dir_z
// out     | output    | out_valid / out_ready| face_index, texel_column, texel_row,
//         |           |                      | zero_vector
// cfg     | input     | cfg_we               | cfg_data (face size)
//
// One request per cycle sustained while the output is not stalled. Stages: a
// select stage, 17 restoring divider stages (one quotient bit each), a
// multiply stage and the output register. Synchronous active-low reset clears
// valids and face size (256). Each stage loads when empty or when the next one
// moves, so bubbles are squeezed out during an output stall.
// ----------------------------------------------------------------------------
module cube_map_face_texel_address_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_dir_x,
  input  logic signed [15:0]          in_dir_y,
  input  logic signed [15:0]          in_dir_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_face_index,
  output logic [11:0]                 out_texel_column,
  output logic [11:0]                 out_texel_row,
  output logic                        out_zero_vector,
  input  logic                        cfg_we,
  input  logic [12:0]                 cfg_data
);

  localparam int NS  = cmfta_pkg::DIV_STAGES;   // divider stages 1..NS
  localparam int MS  = NS + 1;                  // multiply stage
  localparam int OS  = NS + 2;                  // output stage

  logic [cmfta_pkg::SIZE_W-1:0] face_size_r;
  logic [OS:0]                  vld_r;
  logic [OS:0]                  ld;

  cmfta_pkg::div_slot_t st_r [0:NS];
  cmfta_pkg::div_slot_t st_nxt [0:NS];
  cmfta_pkg::div_slot_t sel_nxt;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r <= cmfta_pkg::FACE_SIZE_RST;
    end else if (cfg_we) begin
      face_size_r <= cfg_data;
    end
  end

  // load enables, from the output back
  always_comb begin
    ld[OS] = !vld_r[OS] || out_ready;
    for (int i = OS - 1; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int i = 1; i <= OS; i++) begin
        if (ld[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 0: major axis, orientation, numerators
  logic signed [16:0] ex, ey, ez, ax, ay, az, m, a, b;
  logic signed [17:0] nu, nv;
  logic [2:0]         face_sel;

  always_comb begin
    ex = 17'(in_dir_x);
    ey = 17'(in_dir_y);
    ez = 17'(in_dir_z);
    ax = ex[16] ? -ex : ex;
    ay = ey[16] ? -ey : ey;
    az = ez[16] ? -ez : ez;
    if (ax >= ay && ax >= az) begin
      m = ax;
      b = ez;
      if (ex[16]) begin
        face_sel = cmfta_pkg::FACE_LEFT;
        a        = ey;
      end else begin
        face_sel = cmfta_pkg::FACE_RIGHT;
        a        = -ey;
      end
    end else if (ay >= ax && ay >= az) begin
      m = ay;
      b = ez;
      if (ey > 17'sd0) begin
        face_sel = cmfta_pkg::FACE_BACK;
        a        = ex;
      end else begin
        face_sel = cmfta_pkg::FACE_FRONT;
        a        = -ex;
      end
    end else begin
      m = az;
      a = ex;
      if (ez[16]) begin
        face_sel = cmfta_pkg::FACE_BOTTOM;
        b        = ey;
      end else begin
        face_sel = cmfta_pkg::FACE_TOP;
        b        = -ey;
      end
    end
    nu = 18'(a) + 18'(m);
    nv = 18'(b) + 18'(m);
    sel_nxt.face = face_sel;
    sel_nxt.zero = (m == 17'sd0);
    sel_nxt.d    = {m[15:0], 1'b0};
    sel_nxt.ru   = nu[16:0];
    sel_nxt.rv   = nv[16:0];
    sel_nxt.qu   = '0;
    sel_nxt.qv   = '0;
  end

  // divider stages: one quotient bit per stage for u and v
  always_comb begin
    cmfta_pkg::step_t su, sv;
    st_nxt[0] = sel_nxt;
    for (int k = 1; k <= NS; k++) begin
      su = cmfta_pkg::div_step(st_r[k-1].ru, st_r[k-1].d, k == 1);
      sv = cmfta_pkg::div_step(st_r[k-1].rv, st_r[k-1].d, k == 1);
      st_nxt[k]    = st_r[k-1];
      st_nxt[k].ru = su.rem;
      st_nxt[k].rv = sv.rem;
      st_nxt[k].qu = {st_r[k-1].qu[cmfta_pkg::QW-2:0], su.bit_q};
      st_nxt[k].qv = {st_r[k-1].qv[cmfta_pkg::QW-2:0], sv.bit_q};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= NS; k++) begin
      if (ld[k]) st_r[k] <= st_nxt[k];
    end
  end

  // multiply stage: scale by face size minus one
  logic [cmfta_pkg::TEXEL_W-1:0] s1;
  logic [cmfta_pkg::SIZE_W-1:0]  s_clip;
  logic [cmfta_pkg::QW-1:0]      vinv;
  logic [cmfta_pkg::PROD_W-1:0]  pu_r, pv_r;
  logic [2:0]                    mface_r;
  logic                          mzero_r;

  always_comb begin
    if (face_size_r == '0) s_clip = 13'd1;
    else if (face_size_r > cmfta_pkg::MAX_FACE_SIZE) s_clip = cmfta_pkg::MAX_FACE_SIZE;
    else s_clip = face_size_r;
    s1   = cmfta_pkg::TEXEL_W'(s_clip - 13'd1);
    vinv = cmfta_pkg::COORD_ONE - st_r[NS].qv;
  end

  always_ff @(posedge clk) begin
    if (ld[MS]) begin
      pu_r    <= cmfta_pkg::PROD_W'(st_r[NS].qu) * cmfta_pkg::PROD_W'(s1);
      pv_r    <= cmfta_pkg::PROD_W'(vinv) * cmfta_pkg::PROD_W'(s1);
      mface_r <= st_r[NS].face;
      mzero_r <= st_r[NS].zero;
    end
  end

  // output register (product < 2^28, so no saturation is reached)
  always_ff @(posedge clk) begin
    if (ld[OS]) begin
      out_face_index   <= mface_r;
      out_zero_vector  <= mzero_r;
      out_texel_column <= mzero_r ? '0
                          : pu_r[cmfta_pkg::FRAC_BITS +: cmfta_pkg::TEXEL_W];
      out_texel_row    <= mzero_r ? '0
                          : pv_r[cmfta_pkg::FRAC_BITS +: cmfta_pkg::TEXEL_W];
    end
  end

  assign out_valid = vld_r[OS];

`ifndef SYNTHESIS
  // a result never names a face outside 0..5
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face_index <= cmfta_pkg::FACE_BOTTOM))
    else $error("face index out of range");

  // zero vector gives zero coordinates on the right face
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |->
      (out_texel_column == '0 && out_texel_row == '0
       && out_face_index == cmfta_pkg::FACE_RIGHT))
    else $error("zero vector result malformed");

  // an empty output register never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_texel_column)
                                   && $stable(out_texel_row)))
    else $error("stalled result changed");
`endif

endmodule
